// File: design/sos_pkg.sv
`timescale 1ns / 1ps
package sos_pkg;

    localparam int NUM_ANGLES_DEF = 181;
    localparam int ANGLE_OFFSET   = 90;
    localparam int END_STEP       = 2;
    localparam int MAX_HALF       = 90;
    localparam logic [31:0] MIN_RESET    = 32'd9999;
    localparam logic [15:0] THRESH_RESET = 16'd800;

    localparam logic REG_THRESH = 1'b0;
    localparam logic REG_SWEEP  = 1'b1;

    localparam logic [31:0] TAN_Q16 [MAX_HALF + 1] = '{
        32'd0, 32'd1144, 32'd2289, 32'd3435, 32'd4583, 32'd5734, 32'd6888, 32'd8047,
        32'd9210, 32'd10380, 32'd11556, 32'd12739, 32'd13930, 32'd15130, 32'd16340,
        32'd17560, 32'd18792, 32'd20036, 32'd21294, 32'd22566, 32'd23853, 32'd25157,
        32'd26478, 32'd27818, 32'd29179, 32'd30560, 32'd31964, 32'd33392, 32'd34846,
        32'd36327, 32'd37837, 32'd39378, 32'd40951, 32'd42560, 32'd44205, 32'd45889,
        32'd47615, 32'd49385, 32'd51202, 32'd53070, 32'd54991, 32'd56970, 32'd59009,
        32'd61113, 32'd63287, 32'd65536, 32'd67865, 32'd70279, 32'd72785, 32'd75391,
        32'd78103, 32'd80930, 32'd83882, 32'd86969, 32'd90203, 32'd93595, 32'd97161,
        32'd100917, 32'd104880, 32'd109070, 32'd113512, 32'd118230, 32'd123255,
        32'd128622, 32'd134369, 32'd140542, 32'd147196, 32'd154393, 32'd162207,
        32'd170727, 32'd180059, 32'd190330, 32'd201699, 32'd214359, 32'd228551,
        32'd244584, 32'd262851, 32'd283868, 32'd308323, 32'd337153, 32'd371673,
        32'd413778, 32'd466313, 32'd533748, 32'd623533, 32'd749080, 32'd937208,
        32'd1250501, 32'd1876705, 32'd3754555, 32'hFFFFFFFF
    };

    typedef struct packed {
        logic func;
        logic close;
        logic fwd;
    } t_ctl;

endpackage

// File: design/scan_object_segmenter.sv
`timescale 1ns / 1ps
// Scan object segmenter.
// Input channel (i_in_valid / o_in_ready) takes one transaction per scan sample
// or clear item; output channel (o_out_valid / i_out_ready) returns exactly one
// result transaction per input, in order. Registers ir_threshold (byte 0) and
// sweep_descending (byte 4) sit on the APB port, written with psel, penable and
// pwrite high; pready is always high. Write registers only while the block is idle.
// A result is registered in sos_track, in each sos_size stage, then in the output
// register. Throughput: one item per cycle while no stall or clearing pass holds
// input; the ping memory takes the sample write and the midpoint read on its
// write and read ports in the same cycle. Reset: the edge machine, count and
// minimum return to their initial values, and a clearing pass zeroes every ping
// memory entry in turn, during which o_in_ready stays low.
// Stall: each stage holds when the one after it is full and blocked; input is
// still taken while empty stages remain, and o_in_ready drops once all are full.
module scan_object_segmenter
    import sos_pkg::*;
#(
    parameter int NUM_ANGLES = NUM_ANGLES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic signed [7:0]  i_angle_deg,
    input  logic [15:0]        i_ir_dist,
    input  logic [15:0]        i_ping_dist,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_object_found,
    output logic [7:0]         o_obj_start_index,
    output logic [7:0]         o_obj_end_index,
    output logic [15:0]        o_mid_distance,
    output logic [31:0]        o_obj_size,
    output logic [7:0]         o_obj_count,
    output logic [31:0]        o_min_size,
    output logic signed [7:0]  o_min_angle_deg
);

    localparam int IW = $clog2(NUM_ANGLES);

    logic [15:0]   r_thresh;
    logic          r_sweep;

    logic          w_s1_valid, w_s1_take;
    t_ctl          w_s1_ctl;
    logic [IW-1:0] w_s1_start, w_s1_end, w_s1_mid;
    logic [6:0]    w_s1_half;
    logic [15:0]   w_s1_ping, w_s1_rd;

    logic          w_s3_valid;
    t_ctl          w_s3_ctl;
    logic [IW-1:0] w_s3_start, w_s3_end, w_s3_mid;
    logic [15:0]   w_s3_mid_ping;
    logic [47:0]   w_s3_prod;

    logic          w_en4;
    logic [32:0]   w_size_raw;
    logic [31:0]   w_size;

    logic          r_out_valid;
    logic          r_found;
    logic [7:0]    r_start, r_end;
    logic [15:0]   r_mid_dist;
    logic [31:0]   r_size;
    logic [7:0]    r_count;
    logic [31:0]   r_min;
    logic [IW-1:0] r_min_idx;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SWEEP) ? {31'd0, r_sweep} : {16'd0, r_thresh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_sweep  <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_THRESH: r_thresh <= pwdata[15:0];
                REG_SWEEP:  r_sweep  <= pwdata[0];
                default:    r_sweep  <= r_sweep;
            endcase
        end
    end

    sos_track #(
        .NUM_ANGLES (NUM_ANGLES)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_thresh    (r_thresh),
        .i_sweep     (r_sweep),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_angle_deg (i_angle_deg),
        .i_ir_dist   (i_ir_dist),
        .i_ping_dist (i_ping_dist),
        .i_take      (w_s1_take),
        .o_valid     (w_s1_valid),
        .o_ctl       (w_s1_ctl),
        .o_start     (w_s1_start),
        .o_end       (w_s1_end),
        .o_mid       (w_s1_mid),
        .o_half      (w_s1_half),
        .o_ping      (w_s1_ping),
        .o_rd        (w_s1_rd)
    );

    sos_size #(
        .NUM_ANGLES (NUM_ANGLES)
    ) u_size (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_s1_valid),
        .o_take_up  (w_s1_take),
        .i_ctl      (w_s1_ctl),
        .i_start    (w_s1_start),
        .i_end      (w_s1_end),
        .i_mid      (w_s1_mid),
        .i_half     (w_s1_half),
        .i_ping     (w_s1_ping),
        .i_rd       (w_s1_rd),
        .i_take     (w_en4),
        .o_valid    (w_s3_valid),
        .o_ctl      (w_s3_ctl),
        .o_start    (w_s3_start),
        .o_end      (w_s3_end),
        .o_mid      (w_s3_mid),
        .o_mid_ping (w_s3_mid_ping),
        .o_prod     (w_s3_prod)
    );

    assign w_en4      = !r_out_valid || i_out_ready;
    assign w_size_raw = w_s3_prod[47:15];
    assign w_size     = w_size_raw[32] ? 32'hFFFFFFFF : w_size_raw[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= 8'd0;
            r_min       <= MIN_RESET;
            r_min_idx   <= '0;
        end else if (w_en4) begin
            r_out_valid <= w_s3_valid;
            if (w_s3_valid) begin
                r_found    <= w_s3_ctl.close;
                r_start    <= w_s3_ctl.close ? 8'(w_s3_start) : 8'd0;
                r_end      <= w_s3_ctl.close ? 8'(w_s3_end) : 8'd0;
                r_mid_dist <= w_s3_ctl.close ? w_s3_mid_ping : 16'd0;
                r_size     <= w_s3_ctl.close ? w_size : 32'd0;
                if (w_s3_ctl.func) begin
                    r_count   <= 8'd0;
                    r_min     <= MIN_RESET;
                    r_min_idx <= '0;
                end else if (w_s3_ctl.close) begin
                    if (r_count != 8'hFF) begin
                        r_count <= r_count + 8'd1;
                    end
                    if (w_size < r_min) begin
                        r_min     <= w_size;
                        r_min_idx <= w_s3_mid;
                    end
                end
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_object_found    = r_found;
    assign o_obj_start_index = r_start;
    assign o_obj_end_index   = r_end;
    assign o_mid_distance    = r_mid_dist;
    assign o_obj_size        = r_size;
    assign o_obj_count       = r_count;
    assign o_min_size        = r_min;
    assign o_min_angle_deg   = 8'(r_min_idx) - 8'(ANGLE_OFFSET);

`ifndef NO_ASSERTIONS
    a_found_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_object_found) |-> (o_obj_count != 8'd0))
        else $error("object reported with zero count");

    a_min_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_min <= MIN_RESET)
        else $error("minimum size above its initial value");

    a_no_found_no_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_object_found) |-> (o_obj_size == 32'd0))
        else $error("size reported without an object");
`endif

endmodule

// File: design/sos_track.sv
`timescale 1ns / 1ps
module sos_track
    import sos_pkg::*;
#(
    parameter int NUM_ANGLES = NUM_ANGLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [15:0]                   i_thresh,
    input  logic                          i_sweep,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic signed [7:0]             i_angle_deg,
    input  logic [15:0]                   i_ir_dist,
    input  logic [15:0]                   i_ping_dist,
    input  logic                          i_take,
    output logic                          o_valid,
    output t_ctl                          o_ctl,
    output logic [$clog2(NUM_ANGLES)-1:0] o_start,
    output logic [$clog2(NUM_ANGLES)-1:0] o_end,
    output logic [$clog2(NUM_ANGLES)-1:0] o_mid,
    output logic [6:0]                    o_half,
    output logic [15:0]                   o_ping,
    output logic [15:0]                   o_rd
);

    localparam int IW = $clog2(NUM_ANGLES);
    localparam logic signed [10:0] LAST = 11'(NUM_ANGLES - 1);

    typedef enum logic [1:0] {
        E_NONE,
        E_FRONT,
        E_INSIDE,
        E_BACK
    } t_edge;

    t_edge            r_state, n_state;
    logic [IW-1:0]    r_open, n_open;
    logic             r_busy;
    logic [IW-1:0]    r_clr_addr;
    logic             r_valid;
    t_ctl             r_ctl;
    logic [IW-1:0]    r_start, r_end, r_mid;
    logic [6:0]       r_half;
    logic [15:0]      r_ping;
    logic [15:0]      r_rd;
    logic [15:0]      r_mem [NUM_ANGLES];

    logic             w_en;
    logic             w_accept;
    logic             w_below, w_above;
    logic             w_close;
    logic signed [10:0] w_ang_sum, w_end_sum;
    logic [IW-1:0]    w_idx, w_end, w_width, w_mid_raw, w_mid;
    logic [IW:0]      w_mid_sum;
    logic [9:0]       w_half_w;
    logic [6:0]       w_half;
    logic             w_we;
    logic [IW-1:0]    w_wa;
    logic [15:0]      w_wd;

    function automatic logic [IW-1:0] clamp(input logic signed [10:0] v);
        logic [IW-1:0] r;
        if (v < 11'sd0) begin
            r = '0;
        end else if (v > LAST) begin
            r = IW'(NUM_ANGLES - 1);
        end else begin
            r = v[IW-1:0];
        end
        return r;
    endfunction

    assign w_en       = !r_valid || i_take;
    assign o_in_ready = w_en && !r_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_below   = i_ir_dist < i_thresh;
        w_above   = i_ir_dist > i_thresh;
        w_ang_sum = {{3{i_angle_deg[7]}}, i_angle_deg} + 11'(ANGLE_OFFSET);
        w_idx     = clamp(w_ang_sum);
        w_end_sum = i_sweep ? 11'({1'b0, w_idx}) + 11'(END_STEP)
                            : 11'({1'b0, w_idx}) - 11'(END_STEP);
        w_end     = clamp(w_end_sum);
        w_width   = (w_end >= r_open) ? w_end - r_open : '0;
        w_half_w  = 10'(w_width >> 1);
        w_half    = (w_half_w > 10'(MAX_HALF)) ? 7'(MAX_HALF) : 7'(w_half_w);
        w_mid_sum = {1'b0, r_open} + {1'b0, w_end};
        w_mid_raw = w_mid_sum[IW:1] & ~IW'(1);
        w_mid     = (w_mid_raw > IW'(NUM_ANGLES - 1)) ? IW'(NUM_ANGLES - 1) : w_mid_raw;
        w_close   = !i_func && (r_state == E_BACK) && w_above;
    end

    always_comb begin
        n_state = r_state;
        n_open  = r_open;
        if (w_accept && !i_func) begin
            case (r_state)
                E_NONE: begin
                    if (w_below) begin
                        n_state = E_FRONT;
                        n_open  = w_idx;
                    end
                end
                E_FRONT: begin
                    n_state = w_below ? E_INSIDE : E_NONE;
                end
                E_INSIDE: begin
                    if (w_above) begin
                        n_state = E_BACK;
                    end
                end
                E_BACK: begin
                    n_state = w_above ? E_NONE : E_INSIDE;
                end
                default: begin
                    n_state = E_NONE;
                end
            endcase
        end
    end

    always_comb begin
        w_we = r_busy || (w_accept && !i_func);
        w_wa = r_busy ? r_clr_addr : w_idx;
        w_wd = r_busy ? 16'd0 : i_ping_dist;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_en) begin
            r_rd <= r_mem[w_mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= E_NONE;
            r_open     <= '0;
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            if (r_busy) begin
                if (r_clr_addr == IW'(NUM_ANGLES - 1)) begin
                    r_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + IW'(1);
                end
            end
            if (w_en) begin
                r_valid   <= w_accept;
                r_ctl     <= '{func: i_func, close: w_close, fwd: (w_mid == w_idx)};
                r_start   <= r_open;
                r_end     <= w_end;
                r_mid     <= w_mid;
                r_half    <= w_half;
                r_ping    <= i_ping_dist;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_mid   = r_mid;
    assign o_half  = r_half;
    assign o_ping  = r_ping;
    assign o_rd    = r_rd;

`ifndef NO_ASSERTIONS
    a_close_resets_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_close) |=> (r_state == E_NONE))
        else $error("edge machine not back to none after close");

    a_clear_pass_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> ($past(r_clr_addr) == IW'(NUM_ANGLES - 1)))
        else $error("clearing pass ended early");
`endif

endmodule

// File: design/sos_size.sv
`timescale 1ns / 1ps
module sos_size
    import sos_pkg::*;
#(
    parameter int NUM_ANGLES = NUM_ANGLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_take_up,
    input  t_ctl                          i_ctl,
    input  logic [$clog2(NUM_ANGLES)-1:0] i_start,
    input  logic [$clog2(NUM_ANGLES)-1:0] i_end,
    input  logic [$clog2(NUM_ANGLES)-1:0] i_mid,
    input  logic [6:0]                    i_half,
    input  logic [15:0]                   i_ping,
    input  logic [15:0]                   i_rd,
    input  logic                          i_take,
    output logic                          o_valid,
    output t_ctl                          o_ctl,
    output logic [$clog2(NUM_ANGLES)-1:0] o_start,
    output logic [$clog2(NUM_ANGLES)-1:0] o_end,
    output logic [$clog2(NUM_ANGLES)-1:0] o_mid,
    output logic [15:0]                   o_mid_ping,
    output logic [47:0]                   o_prod
);

    localparam int IW = $clog2(NUM_ANGLES);

    logic          r_v2, r_v3;
    t_ctl          r_ctl2, r_ctl3;
    logic [IW-1:0] r_start2, r_end2, r_mid2;
    logic [IW-1:0] r_start3, r_end3, r_mid3;
    logic [15:0]   r_ping2, r_ping3;
    logic [31:0]   r_tan2;
    logic [47:0]   r_prod3;
    logic          w_en2, w_en3;

    assign w_en3     = !r_v3 || i_take;
    assign w_en2     = !r_v2 || w_en3;
    assign o_take_up = w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en2) begin
                r_v2     <= i_valid;
                r_ctl2   <= i_ctl;
                r_start2 <= i_start;
                r_end2   <= i_end;
                r_mid2   <= i_mid;
                r_ping2  <= i_ctl.fwd ? i_ping : i_rd;
                r_tan2   <= TAN_Q16[i_half];
            end
            if (w_en3) begin
                r_v3     <= r_v2;
                r_ctl3   <= r_ctl2;
                r_start3 <= r_start2;
                r_end3   <= r_end2;
                r_mid3   <= r_mid2;
                r_ping3  <= r_ping2;
                r_prod3  <= 48'(r_ping2) * 48'(r_tan2);
            end
        end
    end

    assign o_valid    = r_v3;
    assign o_ctl      = r_ctl3;
    assign o_start    = r_start3;
    assign o_end      = r_end3;
    assign o_mid      = r_mid3;
    assign o_mid_ping = r_ping3;
    assign o_prod     = r_prod3;

endmodule
